// ----- sv/snu_pkg.sv -----
// Package: request/response payload types, control struct and fixed widths.
package snu_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int OUT_WIDTH   = 16;
   localparam int LANES       = 3;

   localparam logic KIND_CROSS = 1'b0;
   localparam logic KIND_PLANE = 1'b1;

   typedef struct packed {
      logic                          kind;
      logic signed [COORD_WIDTH-1:0] a_x;
      logic signed [COORD_WIDTH-1:0] a_y;
      logic signed [COORD_WIDTH-1:0] a_z;
      logic signed [COORD_WIDTH-1:0] b_x;
      logic signed [COORD_WIDTH-1:0] b_y;
      logic signed [COORD_WIDTH-1:0] b_z;
      logic signed [COORD_WIDTH-1:0] c_x;
      logic signed [COORD_WIDTH-1:0] c_y;
      logic signed [COORD_WIDTH-1:0] c_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] normal_x;
      logic signed [OUT_WIDTH-1:0] normal_y;
      logic signed [OUT_WIDTH-1:0] normal_z;
      logic                        degenerate;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [LANES-1:0] neg;
      logic             degenerate;
   } snu_ctl_type;

endpackage

// ----- sv/snu_root_step.sv -----
// One registered bit step of the three-lane restoring root/quotient search.
module snu_root_step
   import snu_pkg::*;
#(
   parameter int SW  = 70,
   parameter int AW  = 101,
   parameter int QSW = 85,
   parameter int QW  = 15,
   parameter int BIT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  snu_ctl_type       ctl_in,
   input  logic [SW-1:0]     s_in,
   input  logic [AW-1:0]     rem_in [LANES],
   input  logic [QSW-1:0]    qs_in  [LANES],
   input  logic [QW-1:0]     q_in   [LANES],
   output snu_ctl_type       ctl_out,
   output logic [SW-1:0]     s_out,
   output logic [AW-1:0]     rem_out [LANES],
   output logic [QSW-1:0]    qs_out  [LANES],
   output logic [QW-1:0]     q_out   [LANES]
);

   snu_ctl_type    ctl_ff;
   logic [SW-1:0]  s_ff;
   logic [AW-1:0]  rem_ff [LANES];
   logic [QSW-1:0] qs_ff  [LANES];
   logic [QW-1:0]  q_ff   [LANES];
   logic [AW-1:0]  rem_in_next [LANES];
   logic [QSW-1:0] qs_in_next  [LANES];
   logic [QW-1:0]  q_in_next   [LANES];

   // try setting this bit: (q + 2^b)^2 s - q^2 s = 2^(b+1) q s + 2^(2b) s
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         logic [AW-1:0] delta;
         delta = (AW'(qs_in[i]) << (BIT + 1)) + (AW'(s_in) << (2 * BIT));
         if (delta <= rem_in[i]) begin
            rem_in_next[i] = rem_in[i] - delta;
            qs_in_next[i]  = qs_in[i] + (QSW'(s_in) << BIT);
            q_in_next[i]   = q_in[i] | (QW'(1) << BIT);
         end else begin
            rem_in_next[i] = rem_in[i];
            qs_in_next[i]  = qs_in[i];
            q_in_next[i]   = q_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff   <= s_in;
      rem_ff <= rem_in_next;
      qs_ff  <= qs_in_next;
      q_ff   <= q_in_next;
   end

   assign ctl_out = ctl_ff;
   assign s_out   = s_ff;
   assign rem_out = rem_ff;
   assign qs_out  = qs_ff;
   assign q_out   = q_ff;

endmodule

// ----- sv/surface_normal_unit.sv -----
// Top level: pipelined unit normal of a cross product in fixed point.
//
// Each request carries three Q8.8 vectors a, b, c. With kind 0 the unit
// computes n = a x b, with kind 1 n = (b - a) x (c - a), and returns each
// component as the exact quotient n_i * 2^OUT_FRAC_BITS / |n| truncated toward
// zero, in Q1.14 at the default setting. A zero cross product gives a zero
// vector with degenerate set. A request is taken at every clock edge where
// start is high; busy is always low. The response appears on rsp_data with
// rsp_valid high for one cycle, in request order, and the receiver cannot
// stall it. The depth is seven stages of differences, cross products,
// magnitudes, split squares and the sum of squares, then one stage per
// result bit of the shared root-and-divide search (one wide add and compare
// per lane and bit), then the output register.
module surface_normal_unit
   import snu_pkg::*;
#(
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int F   = OUT_FRAC_BITS;
   localparam int DW1 = COORD_WIDTH + 1;   // coordinate differences
   localparam int PW  = 2 * DW1;           // partial cross products
   localparam int NW  = PW + 1;            // cross product components
   localparam int MW  = NW - 1;            // component magnitudes
   localparam int HL  = MW / 2;            // low half of a magnitude
   localparam int HH  = MW - HL;           // high half of a magnitude
   localparam int SQW = 2 * MW;            // squares
   localparam int SW  = SQW + 2;           // sum of three squares
   localparam int AW  = SW + 2 * F + 3;    // remainder and step terms
   localparam int QSW = SW + F + 1;        // running q * s
   localparam int QW  = F + 1;             // quotient bits
   localparam int STEPS = F + 1;

   // stage 1: operand differences
   logic                  v1_ff;
   logic signed [DW1-1:0] dx_ff, dy_ff, dz_ff, ex_ff, ey_ff, ez_ff;
   logic signed [DW1-1:0] dx_in, dy_in, dz_in, ex_in, ey_in, ez_in;
   // stage 2: six partial products
   logic                 v2_ff;
   logic signed [PW-1:0] p_ff [6];
   // stage 3: cross product
   logic                 v3_ff;
   logic signed [NW-1:0] n_ff [LANES];
   // stage 4: magnitudes and signs
   snu_ctl_type          ctl4_ff, ctl4_in;
   logic [MW-1:0]        m_ff [LANES];
   logic [MW-1:0]        m_in [LANES];
   // stage 5: split products of each square
   snu_ctl_type          ctl5_ff;
   logic [2*HH-1:0]      hh_ff [LANES];
   logic [HH+HL-1:0]     hl_ff [LANES];
   logic [2*HL-1:0]      ll_ff [LANES];
   // stage 6: squares
   snu_ctl_type          ctl6_ff;
   logic [SQW-1:0]       sq_ff [LANES];
   // stage 7: sum of squares and search start
   snu_ctl_type          ctl7_ff;
   logic [SW-1:0]        s7_ff;
   logic [AW-1:0]        t7_ff [LANES];

   // search chain
   snu_ctl_type    ctl_chain [STEPS+1];
   logic [SW-1:0]  s_chain   [STEPS+1];
   logic [AW-1:0]  rem_chain [STEPS+1][LANES];
   logic [QSW-1:0] qs_chain  [STEPS+1][LANES];
   logic [QW-1:0]  q_chain   [STEPS+1][LANES];

   // output register
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [OUT_WIDTH-1:0] comp [LANES];

   // the pipeline never stalls, so a new request is always welcome
   assign busy = 1'b0;

   // select plain vectors or edge vectors of the triangle
   always_comb begin
      if (req_data.kind == KIND_PLANE) begin
         dx_in = DW1'(req_data.b_x) - DW1'(req_data.a_x);
         dy_in = DW1'(req_data.b_y) - DW1'(req_data.a_y);
         dz_in = DW1'(req_data.b_z) - DW1'(req_data.a_z);
         ex_in = DW1'(req_data.c_x) - DW1'(req_data.a_x);
         ey_in = DW1'(req_data.c_y) - DW1'(req_data.a_y);
         ez_in = DW1'(req_data.c_z) - DW1'(req_data.a_z);
      end else begin
         dx_in = DW1'(req_data.a_x);
         dy_in = DW1'(req_data.a_y);
         dz_in = DW1'(req_data.a_z);
         ex_in = DW1'(req_data.b_x);
         ey_in = DW1'(req_data.b_y);
         ez_in = DW1'(req_data.b_z);
      end
   end

   // take magnitudes, remember signs, flag the zero vector
   always_comb begin
      ctl4_in.valid      = v3_ff;
      ctl4_in.degenerate = 1'b1;
      for (int i = 0; i < LANES; i++) begin
         ctl4_in.neg[i] = n_ff[i][NW-1];
         m_in[i] = n_ff[i][NW-1] ? MW'(-n_ff[i]) : MW'(n_ff[i]);
         if (n_ff[i] != '0) begin
            ctl4_in.degenerate = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         ctl4_ff <= '0;
         ctl5_ff <= '0;
         ctl6_ff <= '0;
         ctl7_ff <= '0;
      end else begin
         v1_ff   <= start && !busy;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         ctl4_ff <= ctl4_in;
         ctl5_ff <= ctl4_ff;
         ctl6_ff <= ctl5_ff;
         ctl7_ff <= ctl6_ff;
      end
   end

   // datapath registers advance every cycle; valid bits qualify them
   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      dz_ff <= dz_in;
      ex_ff <= ex_in;
      ey_ff <= ey_in;
      ez_ff <= ez_in;

      p_ff[0] <= dy_ff * ez_ff;
      p_ff[1] <= dz_ff * ey_ff;
      p_ff[2] <= dz_ff * ex_ff;
      p_ff[3] <= dx_ff * ez_ff;
      p_ff[4] <= dx_ff * ey_ff;
      p_ff[5] <= dy_ff * ex_ff;

      n_ff[0] <= NW'(p_ff[0]) - NW'(p_ff[1]);
      n_ff[1] <= NW'(p_ff[2]) - NW'(p_ff[3]);
      n_ff[2] <= NW'(p_ff[4]) - NW'(p_ff[5]);

      m_ff <= m_in;

      for (int i = 0; i < LANES; i++) begin
         hh_ff[i] <= (2*HH)'(m_ff[i][MW-1:HL]) * (2*HH)'(m_ff[i][MW-1:HL]);
         hl_ff[i] <= (HH+HL)'(m_ff[i][MW-1:HL]) * (HH+HL)'(m_ff[i][HL-1:0]);
         ll_ff[i] <= (2*HL)'(m_ff[i][HL-1:0]) * (2*HL)'(m_ff[i][HL-1:0]);
         sq_ff[i] <= (SQW'(hh_ff[i]) << (2 * HL)) + (SQW'(hl_ff[i]) << (HL + 1))
                     + SQW'(ll_ff[i]);
         t7_ff[i] <= AW'(sq_ff[i]) << (2 * F);
      end
      s7_ff <= SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
   end

   // seed the search: remainder is n_i^2 * 2^(2F), nothing taken yet
   assign ctl_chain[0] = ctl7_ff;
   assign s_chain[0]   = s7_ff;
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         rem_chain[0][i] = t7_ff[i];
         qs_chain[0][i]  = '0;
         q_chain[0][i]   = '0;
      end
   end

   // one stage per quotient bit, most significant first
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      snu_root_step #(
         .SW (SW),
         .AW (AW),
         .QSW(QSW),
         .QW (QW),
         .BIT(F - k)
      ) u_step (
         .clock  (clock),
         .reset  (reset),
         .ctl_in (ctl_chain[k]),
         .s_in   (s_chain[k]),
         .rem_in (rem_chain[k]),
         .qs_in  (qs_chain[k]),
         .q_in   (q_chain[k]),
         .ctl_out(ctl_chain[k+1]),
         .s_out  (s_chain[k+1]),
         .rem_out(rem_chain[k+1]),
         .qs_out (qs_chain[k+1]),
         .q_out  (q_chain[k+1])
      );
   end

   // restore signs, wrap to the output width, drop a zero vector
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (ctl_chain[STEPS].degenerate) begin
            comp[i] = '0;
         end else if (ctl_chain[STEPS].neg[i]) begin
            comp[i] = OUT_WIDTH'(0) - OUT_WIDTH'(q_chain[STEPS][i]);
         end else begin
            comp[i] = OUT_WIDTH'(q_chain[STEPS][i]);
         end
      end
      rsp_data_in.normal_x   = comp[0];
      rsp_data_in.normal_y   = comp[1];
      rsp_data_in.normal_z   = comp[2];
      rsp_data_in.degenerate = ctl_chain[STEPS].degenerate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_chain[STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/snu_checker.sv -----
// Checker: port-level timing and result checks, bound to the top level.
module snu_checker
   import snu_pkg::*;
#(
   parameter int LATENCY = 23
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised on a non-stalling pipeline");

   a_request_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("request not answered at fixed latency");

   a_no_spurious_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, LATENCY))
      else $error("response without matching request");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.degenerate) |->
         (rsp_data.normal_x == '0 && rsp_data.normal_y == '0 &&
          rsp_data.normal_z == '0))
      else $error("degenerate response with nonzero normal");

endmodule

bind surface_normal_unit snu_checker #(.LATENCY(OUT_FRAC_BITS + 9)) u_snu_checker (.*);
